// File: hdl/u2u8_pkg.sv
package u2u8_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  // final status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ODD        = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE = 3'd2;
  localparam logic [2:0] ST_BADLOW     = 3'd3;
  localparam logic [2:0] ST_LONELOW    = 3'd4;

  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [20:0] MAX_1BYTE   = 21'h7F;
  localparam logic [20:0] MAX_2BYTE   = 21'h7FF;
  localparam logic [20:0] MAX_3BYTE   = 21'hFFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       run_last;
    logic       text_done;
  } out_item_t;

  // one queued job: a code point to encode, or a status-only close
  typedef struct packed {
    logic [20:0] cp;
    logic [1:0]  last_idx;  // encoded length minus one
    logic        stat_only;
    logic [2:0]  status;
    logic        done;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // number of UTF-8 bytes minus one for a code point
  function automatic logic [1:0] utf8_last_idx(logic [20:0] cp);
    logic [1:0] r;
    if (cp <= MAX_1BYTE) begin
      r = 2'd0;
    end else if (cp <= MAX_2BYTE) begin
      r = 2'd1;
    end else if (cp <= MAX_3BYTE) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  // byte idx of the UTF-8 encoding of cp
  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [1:0] last_idx,
                                           logic [1:0] idx);
    logic [7:0] b;
    logic [1:0] k;
    k = last_idx - idx;
    if (idx == 2'd0) begin
      case (last_idx)
        2'd0:    b = {1'b0, cp[6:0]};
        2'd1:    b = {3'b110, cp[10:6]};
        2'd2:    b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (k)
        2'd0:    b = {2'b10, cp[5:0]};
        2'd1:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

// File: hdl/u2u8_queue.sv
module u2u8_queue #(
  parameter int unsigned Depth = u2u8_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u2u8_pkg::job_t   push_job_i,
  input  logic             pop_i,
  output u2u8_pkg::job_t   head_job_o,
  output u2u8_pkg::qstat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u2u8_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  assign head_job_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// File: hdl/u2u8_front.sv
module u2u8_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  u2u8_pkg::in_item_t in_item_i,
  output logic               in_ready_o,
  input  u2u8_pkg::qstat_t   qstat_i,
  output logic               push_o,
  output u2u8_pkg::job_t     push_job_o
);

  logic        odd_q, odd_d;
  logic [7:0]  held_q, held_d;
  logic        hp_q, hp_d;
  logic [9:0]  hb_q, hb_d;
  logic [2:0]  err_q, err_d;

  logic        accept;
  logic [15:0] unit;
  logic        is_hi, is_lo, enc;
  logic [20:0] cp;
  logic [2:0]  st;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign unit       = {in_item_i.in_byte, held_q};
  assign is_hi      = (unit >= u2u8_pkg::HI_SURR_MIN) && (unit <= u2u8_pkg::HI_SURR_MAX);
  assign is_lo      = (unit >= u2u8_pkg::LO_SURR_MIN) && (unit <= u2u8_pkg::LO_SURR_MAX);

  always_comb begin
    odd_d      = odd_q;
    held_d     = held_q;
    hp_d       = hp_q;
    hb_d       = hb_q;
    err_d      = err_q;
    enc        = 1'b0;
    cp         = {5'd0, unit};
    st         = u2u8_pkg::ST_OK;
    push_o     = 1'b0;
    push_job_o = '0;
    if (accept) begin
      if (!odd_q) begin
        held_d = in_item_i.in_byte;
        odd_d  = 1'b1;
        if (in_item_i.end_of_text) begin
          push_o               = 1'b1;
          push_job_o.stat_only = 1'b1;
          push_job_o.status    = u2u8_pkg::ST_ODD;
          push_job_o.done      = 1'b1;
        end
      end else begin
        odd_d = 1'b0;
        if (err_q == u2u8_pkg::ST_OK) begin
          if (hp_q) begin
            hp_d = 1'b0;
            if (is_lo) begin
              cp  = u2u8_pkg::SUPP_BASE + {1'b0, hb_q, unit[9:0]};
              enc = 1'b1;
            end else begin
              err_d = u2u8_pkg::ST_BADLOW;
            end
          end else if (is_hi) begin
            hp_d = 1'b1;
            hb_d = unit[9:0];
          end else if (is_lo) begin
            err_d = u2u8_pkg::ST_LONELOW;
          end else begin
            enc = 1'b1;
          end
        end
        push_job_o.cp       = cp;
        push_job_o.last_idx = u2u8_pkg::utf8_last_idx(cp);
        if (!in_item_i.end_of_text) begin
          push_o = enc;
        end else begin
          st = err_d;
          if (st == u2u8_pkg::ST_OK && hp_d) begin
            st = u2u8_pkg::ST_INCOMPLETE;
          end
          push_o          = 1'b1;
          push_job_o.done = 1'b1;
          if (st != u2u8_pkg::ST_OK || !enc) begin
            push_job_o.stat_only = 1'b1;
            push_job_o.status    = st;
          end
        end
      end
      if (in_item_i.end_of_text) begin
        // text closed: back to the reset state
        odd_d  = 1'b0;
        held_d = '0;
        hp_d   = 1'b0;
        hb_d   = '0;
        err_d  = u2u8_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q  <= 1'b0;
      held_q <= '0;
      hp_q   <= 1'b0;
      hb_q   <= '0;
      err_q  <= u2u8_pkg::ST_OK;
    end else begin
      odd_q  <= odd_d;
      held_q <= held_d;
      hp_q   <= hp_d;
      hb_q   <= hb_d;
      err_q  <= err_d;
    end
  end

endmodule

// File: hdl/u2u8_back.sv
module u2u8_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  u2u8_pkg::job_t      head_job_i,
  input  u2u8_pkg::qstat_t    qstat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u2u8_pkg::out_item_t out_item_o
);

  logic [1:0]          idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  u2u8_pkg::out_item_t out_q, out_d;
  logic                load, emit, last;

  assign load = !out_valid_q || out_ready_i;
  assign emit = load && !qstat_i.empty;
  assign last = head_job_i.stat_only || (idx_q == head_job_i.last_idx);
  assign pop_o = emit && last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_valid_d = !qstat_i.empty;
    end
    if (emit) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
      if (head_job_i.stat_only) begin
        out_d.out_byte   = '0;
        out_d.byte_valid = 1'b0;
        out_d.status     = head_job_i.status;
      end else begin
        out_d.out_byte   = u2u8_pkg::utf8_byte(head_job_i.cp, head_job_i.last_idx, idx_q);
        out_d.byte_valid = 1'b1;
        out_d.status     = u2u8_pkg::ST_OK;
      end
      out_d.run_last  = last;
      out_d.text_done = last && head_job_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hdl/utf16le_to_utf8_transcoder_core.sv
// Channel   Handshake                  Payload                 Per transaction
// --------  -------------------------  ----------------------  --------------------------
// in        in_valid_i / in_ready_o    in_item_i  (in_item_t)  one UTF-16LE byte (+ end)
// out       out_valid_o / out_ready_i  out_item_o (out_item_t) one UTF-8 byte or status
//
// Input takes one byte per cycle while the job queue has room; output gives one
// byte per cycle while out_ready_i allows. A code unit yields 0 to 3 output bytes
// and a surrogate pair 4, walked one per cycle (unless the output stalls) by the
// back-end byte sequencer, so the output port sets the sustained rate.
// Reset (rst_ni, async, low) empties the queue and returns the decoder to the start
// of a text. A stalled output holds its register; the queue then fills and in_ready_o
// drops.
module utf16le_to_utf8_transcoder_core #(
  parameter int unsigned QueueDepth = u2u8_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u2u8_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u2u8_pkg::out_item_t out_item_o
);

  // front end: pairs bytes into code units, joins surrogates, tracks errors
  logic             push;
  logic             pop;
  u2u8_pkg::job_t   push_job;
  u2u8_pkg::job_t   head_job;
  u2u8_pkg::qstat_t qstat;

  u2u8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready_o),
    .qstat_i    (qstat),
    .push_o     (push),
    .push_job_o (push_job)
  );

  // short job queue decouples the front end from output stalls
  u2u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_job_o (head_job),
    .stat_o     (qstat)
  );

  // back end: emits the UTF-8 bytes or status of each job through the output register
  u2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_job_i  (head_job),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // never write a full queue that is not popped at the same time
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && qstat.full && !pop))
    else $error("job queue overflow");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && qstat.empty))
    else $error("job queue underflow");

  // status-only results always close the text
  a_status_only_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.byte_valid |-> out_item_o.run_last && out_item_o.text_done)
    else $error("status-only result not final");

  // a nonzero status appears only on the final result
  a_status_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != u2u8_pkg::ST_OK) |-> out_item_o.text_done)
    else $error("error status before end of text");

endmodule

// File: verif/utf16le_to_utf8_transcoder_core_tb.sv
module utf16le_to_utf8_transcoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock, reset and the block's ports. Inputs start at known values.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  u2u8_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  u2u8_pkg::out_item_t out_item_o;

  utf16le_to_utf8_transcoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // 2 ns period, first rising edge at 1 ns.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Byte transactions waiting for the driver, and UTF-8 results waiting for the monitor.
  u2u8_pkg::in_item_t  pending_bytes_q[$];
  u2u8_pkg::out_item_t utf8_expect_q[$];
  logic [15:0]         text_units[$];   // code units of the text being built

  // Predictor copy of the decoder state.
  logic        u16_odd_phase;
  logic [7:0]  u16_held_low;
  logic        u16_high_pending;
  logic [9:0]  u16_high_bits;
  logic [2:0]  u16_error;

  // Bookkeeping.
  int unsigned bytes_queued     = 0;
  int unsigned bytes_accepted   = 0;
  int unsigned results_checked  = 0;
  int unsigned texts_sent       = 0;
  int unsigned check_errors     = 0;
  int unsigned status_hits[5];
  bit          in_accepted      = 1'b0;  // set at the edge that took the byte
  bit          flood_armed      = 1'b0;
  bit          flood_done       = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic u2u8_pkg::out_item_t make_result(logic [7:0] b, logic bv,
                                                      logic [2:0] st, logic last,
                                                      logic done);
    u2u8_pkg::out_item_t r;
    r.out_byte   = b;
    r.byte_valid = bv;
    r.status     = st;
    r.run_last   = last;
    r.text_done  = done;
    return r;
  endfunction

  // Append one expected result.
  function automatic void add_expect(u2u8_pkg::out_item_t r);
    utf8_expect_q = {utf8_expect_q, r};
  endfunction

  // Append one code unit to the text being built.
  function automatic void add_unit(logic [15:0] u);
    text_units = {text_units, u};
  endfunction

  function automatic void clear_text_state();
    u16_odd_phase    = 1'b0;
    u16_held_low     = '0;
    u16_high_pending = 1'b0;
    u16_high_bits    = '0;
    u16_error        = u2u8_pkg::ST_OK;
  endfunction

  // Close a text with a status-only transaction.
  function automatic void close_with_status(logic [2:0] st);
    add_expect(make_result(8'h00, 1'b0, st, 1'b1, 1'b1));
    status_hits[st]++;
    clear_text_state();
  endfunction

  // Advance the decoder by one byte and queue the UTF-8 bytes it yields.
  function automatic void predict_utf8(u2u8_pkg::in_item_t item);
    logic [15:0] code_unit;
    logic [20:0] cp;
    logic [7:0]  enc[4];
    logic [2:0]  st;
    bit          have_cp;
    int          n;

    have_cp = 1'b0;
    n       = 0;
    cp      = '0;

    // low byte: just hold it, unless the text ends on it (odd length)
    if (!u16_odd_phase) begin
      u16_held_low  = item.in_byte;
      u16_odd_phase = 1'b1;
      if (item.end_of_text) close_with_status(u2u8_pkg::ST_ODD);
      return;
    end

    u16_odd_phase = 1'b0;
    if (u16_error == u2u8_pkg::ST_OK) begin
      code_unit = {item.in_byte, u16_held_low};
      if (u16_high_pending) begin
        u16_high_pending = 1'b0;
        if (code_unit >= u2u8_pkg::LO_SURR_MIN && code_unit <= u2u8_pkg::LO_SURR_MAX) begin
          cp      = u2u8_pkg::SUPP_BASE + {1'b0, u16_high_bits, code_unit[9:0]};
          have_cp = 1'b1;
        end else begin
          u16_error = u2u8_pkg::ST_BADLOW;
        end
      end else if (code_unit >= u2u8_pkg::HI_SURR_MIN &&
                   code_unit <= u2u8_pkg::HI_SURR_MAX) begin
        u16_high_pending = 1'b1;
        u16_high_bits    = code_unit[9:0];
      end else if (code_unit >= u2u8_pkg::LO_SURR_MIN &&
                   code_unit <= u2u8_pkg::LO_SURR_MAX) begin
        u16_error = u2u8_pkg::ST_LONELOW;
      end else begin
        cp      = {5'b0, code_unit};
        have_cp = 1'b1;
      end
    end

    if (have_cp) begin
      if (cp < 21'h80) begin
        enc[0] = cp[7:0];
        n = 1;
      end else if (cp < 21'h800) begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
        n = 2;
      end else if (cp < 21'h10000) begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
        n = 3;
      end else begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
        n = 4;
      end
    end

    if (!item.end_of_text) begin
      for (int i = 0; i < n; i++)
        add_expect(make_result(enc[i], 1'b1, u2u8_pkg::ST_OK, i == n - 1, 1'b0));
      return;
    end

    // final byte of the text
    st = u16_error;
    if (st == u2u8_pkg::ST_OK && u16_high_pending) st = u2u8_pkg::ST_INCOMPLETE;
    if (st != u2u8_pkg::ST_OK || n == 0) begin
      close_with_status(st);
    end else begin
      // clean text: last UTF-8 byte carries the done flag, no extra status transaction
      for (int i = 0; i < n; i++)
        add_expect(make_result(enc[i], 1'b1, u2u8_pkg::ST_OK, i == n - 1, i == n - 1));
      status_hits[u2u8_pkg::ST_OK]++;
      clear_text_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Text builders
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b, logic last);
    u2u8_pkg::in_item_t item;
    item.in_byte     = b;
    item.end_of_text = last;
    pending_bytes_q = {pending_bytes_q, item};
    bytes_queued++;
  endfunction

  // Turn text_units into bytes, low byte first; an odd tail adds one stray byte.
  function automatic void flush_text(bit odd_tail);
    int nu;
    nu = text_units.size();
    for (int i = 0; i < nu; i++) begin
      push_byte(text_units[i][7:0], 1'b0);
      push_byte(text_units[i][15:8], (i == nu - 1) && !odd_tail);
    end
    if (odd_tail) push_byte(8'($urandom_range(0, 255)), 1'b1);
    text_units.delete();
    texts_sent++;
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'($urandom_range(u2u8_pkg::HI_SURR_MIN, u2u8_pkg::HI_SURR_MAX));
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'($urandom_range(u2u8_pkg::LO_SURR_MIN, u2u8_pkg::LO_SURR_MAX));
  endfunction

  // Any non-surrogate unit, spread over the 1/2/3-byte encodings and their edges.
  function automatic logic [15:0] rand_scalar();
    logic [15:0] u;
    case ($urandom_range(0, 5))
      0, 1: u = 16'($urandom_range(16'h0000, 16'h007F));
      2:    u = 16'($urandom_range(16'h0080, 16'h07FF));
      3:    u = 16'($urandom_range(16'h0800, 16'hD7FF));
      4:    u = 16'($urandom_range(16'hE000, 16'hFFFF));
      default: begin
        case ($urandom_range(0, 7))
          0:       u = 16'h0000;
          1:       u = 16'h007F;
          2:       u = 16'h0080;
          3:       u = 16'h07FF;
          4:       u = 16'h0800;
          5:       u = 16'hD7FF;
          6:       u = 16'hE000;
          default: u = 16'hFFFF;
        endcase
      end
    endcase
    return u;
  endfunction

  // Mostly well-formed texts; some carry one flaw, some are pure noise.
  function automatic void add_random_text();
    int nu;
    int flaw;
    nu   = $urandom_range(1, 6);
    flaw = $urandom_range(0, 11);
    for (int i = 0; i < nu; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        add_unit(rand_high());
        add_unit(rand_low());
      end else if (flaw == 5) begin
        add_unit(16'($urandom_range(0, 16'hFFFF)));
      end else begin
        add_unit(rand_scalar());
      end
    end
    case (flaw)
      0, 4: add_unit(rand_low());                      // lone low surrogate
      1: begin                                         // high followed by a non-low unit
        add_unit(rand_high());
        add_unit($urandom_range(0, 1) ? rand_scalar() : rand_high());
      end
      2: add_unit(rand_high());                        // high surrogate left dangling
      default: ;
    endcase
    // trailing units after an error get dropped by the block
    if (flaw == 0 || flaw == 1)
      for (int i = $urandom_range(0, 3); i > 0; i--) add_unit(rand_scalar());
    flush_text(flaw == 3 || flaw == 4);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: prediction on accepted input, checking on accepted output
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      check_errors++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    u2u8_pkg::out_item_t want;
    if (rst_ni) begin
      // predict first so a same-edge result would still find its expectation
      if (in_valid_i && in_ready_o) begin
        predict_utf8(in_item_i);
        in_accepted = 1'b1;
        bytes_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (utf8_expect_q.size() == 0) begin
          $display("%0t ns: unexpected transaction, expected none, got %p",
                   $time, out_item_o);
          check_errors++;
        end else begin
          want = utf8_expect_q.pop_front();
          check_field("out_byte",   want.out_byte,   out_item_o.out_byte);
          check_field("byte_valid", want.byte_valid, out_item_o.byte_valid);
          check_field("status",     want.status,     out_item_o.status);
          check_field("run_last",   want.run_last,   out_item_o.run_last);
          check_field("text_done",  want.text_done,  out_item_o.text_done);
          results_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of back-to-back bytes separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin : driver
    if (rst_ni) begin
      // hold the offered byte until it was taken
      if (!in_valid_i || in_accepted) begin
        in_accepted = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_bytes_q.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switching between modes, plus one long hold-off
  // once the random phase starts so the job queue backs up into in_ready_o.
  // ---------------------------------------------------------------------------
  int stall_cycle = 0;
  int stall_mode  = 0;
  int flood_left  = 0;

  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      stall_cycle++;
      if (stall_cycle % 40 == 0) stall_mode = $urandom_range(0, 3);
      if (flood_armed && !flood_done) begin
        flood_left = 150;
        flood_done = 1'b1;
      end
      if (flood_left > 0) begin
        flood_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((stall_cycle % 8) < 5);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_start;
    clear_text_state();
    foreach (status_hits[i]) status_hits[i] = 0;

    // Directed texts.
    // The 1-, 2- and 3-byte encodings, at edges 0000, 007F, 0080 and FFFF.
    text_units = '{16'h0000, 16'h007F, 16'h0080, 16'hFFFF};
    flush_text(1'b0);
    // Smallest and largest supplementary code points.
    text_units = '{16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF};
    flush_text(1'b0);
    // One-byte text: odd length.
    flush_text(1'b1);
    // Text ends on a high surrogate: incomplete pair.
    text_units = '{16'hD800};
    flush_text(1'b0);
    // High surrogate then a plain unit, plus a stray byte: odd length wins.
    text_units = '{16'hDBFF, 16'h0041};
    flush_text(1'b1);
    // Lone low surrogate, later units dropped.
    text_units = '{16'hDFFF, 16'h0020};
    flush_text(1'b0);
    // High surrogate followed by another high surrogate.
    text_units = '{16'hD800, 16'hDBFF};
    flush_text(1'b0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sender pause: let every directed result come out before going on.
    while (bytes_accepted != bytes_queued || utf8_expect_q.size() != 0) @(negedge clk_i);

    @(posedge clk_i);
    flood_armed  = 1'b1;
    random_start = bytes_queued;
    while (bytes_queued - random_start < 150) add_random_text();

    while (bytes_accepted != bytes_queued || utf8_expect_q.size() != 0) @(negedge clk_i);
    // keep clocking to catch anything emitted beyond the last expectation
    repeat (20) @(posedge clk_i);

    $display("Sent %0d texts (%0d bytes), checked %0d UTF-8 transactions.",
             texts_sent, bytes_queued, results_checked);
    $display("Text closes: ok %0d, odd %0d, incomplete %0d, bad low %0d, lone low %0d.",
             status_hits[u2u8_pkg::ST_OK], status_hits[u2u8_pkg::ST_ODD],
             status_hits[u2u8_pkg::ST_INCOMPLETE], status_hits[u2u8_pkg::ST_BADLOW],
             status_hits[u2u8_pkg::ST_LONELOW]);
    if (check_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #200000;
    $display("Timeout with %0d results still outstanding.", utf8_expect_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
